// ===== src/bd_pkg.sv =====
// Shared types, codes and the character table of the base64 decoder.
package bd_pkg;

   // Depth of the queue between front and back ends
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   // Error codes as reported on the result channel
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_CHAR   = 2'd1;
   localparam logic [1:0] ERR_LENGTH = 2'd2;
   localparam logic [1:0] ERR_PAD    = 2'd3;

   // Sextet classes beyond the 64 data values
   localparam logic [6:0] SEXTET_PAD = 7'd64;
   localparam logic [6:0] SEXTET_BAD = 7'd65;

   // Result counts a request can cause
   localparam logic [1:0] NRES_NONE  = 2'd0;
   localparam logic [1:0] NRES_ONE   = 2'd1;
   localparam logic [1:0] NRES_TWO   = 2'd2;
   localparam logic [1:0] NRES_THREE = 2'd3;

   // One queue entry: the results one request causes
   typedef struct packed {
      logic [23:0] word;     // up to three bytes, first in the top byte
      logic [1:0]  nres;     // number of results, one to three
      logic        is_err;   // single error result instead of bytes
      logic [1:0]  err;      // error code when is_err
      logic        eos;      // last result closes the stream
   } job_type;

   // Alphabet lookup: 0..63 data, SEXTET_PAD for '=', SEXTET_BAD otherwise
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      v = SEXTET_BAD;
      if (c >= 8'h41 && c <= 8'h5a) begin          // 'A'..'Z'
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7a) begin // 'a'..'z'
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin // '0'..'9'
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2b) begin               // '+'
         v = 7'd62;
      end else if (c == 8'h2f) begin               // '/'
         v = 7'd63;
      end else if (c == 8'h3d) begin               // '='
         v = SEXTET_PAD;
      end
      return v;
   endfunction

endpackage

// ===== src/bd_req_if.sv =====
// Request channel: one character and its end-of-stream flag.
interface bd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       final_char;

   modport source (output valid, output char_code, output final_char, input ready);
   modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

// ===== src/bd_rsp_if.sv =====
// Result channel: one decoded byte or error report.
interface bd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       has_byte;
   logic [1:0] error_code;
   logic       end_of_run;
   logic       end_of_stream;

   modport source (output valid, output byte_out, output has_byte, output error_code,
                   output end_of_run, output end_of_stream, input ready);
   modport sink   (input valid, input byte_out, input has_byte, input error_code,
                   input end_of_run, input end_of_stream, output ready);
endinterface

// ===== src/bd_front.sv =====
// Front end: classifies characters, tracks group state, builds result jobs.
module bd_front import bd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bd_req_if.sink      req_ch,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic [17:0] bits_ff, bits_in;
   logic [1:0]  pos_ff, pos_in;
   logic [1:0]  pad_ff, pad_in;
   logic [1:0]  perr_ff, perr_in;

   logic        accept;
   logic [6:0]  v;
   logic        group_full;
   logic [1:0]  pos_next;
   logic [1:0]  err;
   job_type     job;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;

   always_comb begin
      v          = sextet_of(req_ch.char_code);
      bits_in    = bits_ff;
      pad_in     = pad_ff;
      perr_in    = perr_ff;
      group_full = 1'b0;
      job        = '0;

      if (v == SEXTET_BAD) begin
         perr_in = ERR_CHAR;               // outranks an earlier padding error
      end else if (perr_ff == ERR_NONE) begin
         if (v == SEXTET_PAD) begin
            if (pos_ff < 2'd2 || (pos_ff == 2'd3 && !req_ch.final_char)) begin
               perr_in = ERR_PAD;
            end else begin
               pad_in = pad_ff + 2'd1;
            end
         end else if (pad_ff != 2'd0) begin
            perr_in = ERR_PAD;             // data after '='
         end else if (pos_ff != 2'd3) begin
            bits_in = {bits_ff[11:0], v[5:0]};
         end else begin
            group_full = 1'b1;
            job.word   = {bits_ff, v[5:0]};
         end
      end

      pos_next = pos_ff + 2'd1;
      pos_in   = pos_next;
      err      = (pos_next != 2'd0) ? ERR_LENGTH : perr_in;

      if (req_ch.final_char) begin
         job.eos = 1'b1;
         if (err != ERR_NONE) begin
            job.is_err = 1'b1;
            job.err    = err;
            job.nres   = NRES_ONE;
         end else if (group_full) begin
            job.nres = NRES_THREE;
         end else if (pad_in == 2'd1) begin
            job.word = {bits_in, 6'd0};
            job.nres = NRES_TWO;
         end else begin
            job.word = {bits_in[11:0], 12'd0};
            job.nres = NRES_ONE;
         end
         // stream ends: back to reset state
         bits_in = '0;
         pos_in  = '0;
         pad_in  = '0;
         perr_in = ERR_NONE;
      end else if (group_full) begin
         job.nres = NRES_THREE;
         bits_in  = '0;
      end
   end

   assign q_push = accept && (job.nres != NRES_NONE);
   assign q_job  = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
         pos_ff  <= '0;
         pad_ff  <= '0;
         perr_ff <= ERR_NONE;
      end else if (accept) begin
         bits_ff <= bits_in;
         pos_ff  <= pos_in;
         pad_ff  <= pad_in;
         perr_ff <= perr_in;
      end
   end

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.final_char) |=> (pos_ff == 2'd0 && perr_ff == ERR_NONE
                                         && pad_ff == 2'd0))
      else $error("group state not cleared after final character");

   a_error_closes: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_job.is_err) |-> (q_job.eos && q_job.nres == NRES_ONE))
      else $error("error job not a single closing result");

endmodule

// ===== src/bd_queue.sv =====
// Short job queue between front and back ends.
module bd_queue import bd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

endmodule

// ===== src/bd_back.sv =====
// Back end: expands queued jobs into results, one per cycle while the result channel is ready, into an output register.
module bd_back import bd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  job_type     q_head,
   output logic        q_pop,
   bd_rsp_if.source    rsp_ch
);

   logic [1:0] k_ff, k_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic [1:0] err_ff, err_in;
   logic       eor_ff, eor_in;
   logic       eos_ff, eos_in;

   logic       take;
   logic       emit;
   logic       last;
   logic [7:0] sel_byte;

   assign take  = !valid_ff || rsp_ch.ready;
   assign emit  = take && !q_empty;
   assign last  = (k_ff == q_head.nres - 2'd1);
   assign q_pop = emit && last;

   always_comb begin
      unique case (k_ff)
         2'd0:    sel_byte = q_head.word[23:16];
         2'd1:    sel_byte = q_head.word[15:8];
         default: sel_byte = q_head.word[7:0];
      endcase
   end

   always_comb begin
      k_in     = k_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      has_in   = has_ff;
      err_in   = err_ff;
      eor_in   = eor_ff;
      eos_in   = eos_ff;
      if (take) begin
         valid_in = !q_empty;
      end
      if (emit) begin
         k_in    = last ? 2'd0 : k_ff + 2'd1;
         byte_in = q_head.is_err ? 8'd0 : sel_byte;
         has_in  = !q_head.is_err;
         err_in  = q_head.is_err ? q_head.err : ERR_NONE;
         eor_in  = last;
         eos_in  = last && q_head.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      has_ff  <= has_in;
      err_ff  <= err_in;
      eor_ff  <= eor_in;
      eos_ff  <= eos_in;
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.byte_out      = byte_ff;
   assign rsp_ch.has_byte      = has_ff;
   assign rsp_ch.error_code    = err_ff;
   assign rsp_ch.end_of_run    = eor_ff;
   assign rsp_ch.end_of_stream = eos_ff;

   a_index_in_job: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> (k_ff < q_head.nres))
      else $error("result index beyond job length");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !has_ff) |-> (err_ff != ERR_NONE && eos_ff && eor_ff))
      else $error("byteless result without error report");

endmodule

// ===== src/base64_decoder.sv =====
// Base64 decoder top level: front end, job queue and back end.
// Path: the first result of a request goes through the job queue and then the back end's
//   output register before it shows on rsp_ch.
// Throughput: one request per cycle while the queue has room and one result per cycle while
//   rsp_ch is ready; the back end's single output register sets the result rate.
// Reset: synchronous and active high; clears group state, queue pointers and output valid.
module base64_decoder import bd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   bd_req_if.sink   req_ch,
   bd_rsp_if.source rsp_ch
);

   // front to queue
   logic    q_push;
   job_type q_job;
   logic    q_full;

   // queue to back
   logic    q_pop;
   logic    q_empty;
   job_type q_head;

   // Front end takes a request each cycle the queue has room; a request that
   // causes no result (mid-group character) only updates the group state.
   bd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_job  (q_job)
   );

   // Queue lets the front run on while the back end drains three-byte groups
   // or waits on a stalled result channel.
   bd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   // Back end walks each job's results in order and pops it after the last.
   bd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule
